### src/ray_circle_nearest_hit_assert.svh
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit_assert.svh
// Assertion helpers used by the back part of the ray/circle hit search.
// ----------------------------------------------------------------------------
`ifndef RAY_CIRCLE_NEAREST_HIT_ASSERT_SVH
`define RAY_CIRCLE_NEAREST_HIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCNH_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCNH_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rcnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_pkg
// Types and constants of the ray/circle nearest hit search.
// ----------------------------------------------------------------------------
package rcnh_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned REL_W      = COORD_W + 1;
  localparam int unsigned PROD_W     = REL_W + DIR_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned NEAR_W     = 32;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_DIR_X        = 3'd2,
    REG_DIR_Y        = 3'd3,
    REG_MAX_DISTANCE = 3'd4
  } rcnh_reg_e;

  // Ray setup handed to the front and back parts
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic [LEN_W-1:0]          max_distance;
  } rcnh_cfg_t;

  // Classified target as held in the queue (scan position travels beside it)
  typedef struct packed {
    logic signed [REL_W-1:0] rel_x;
    logic signed [REL_W-1:0] rel_y;
    logic [LEN_W-1:0]        radius;
    logic                    eligible;
    logic                    last;
  } rcnh_geom_t;

  localparam int unsigned GEOM_W = $bits(rcnh_geom_t);

endpackage

### src/rcnh_target_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_target_if
// Valid/ready channel carrying one circular target word.
// ----------------------------------------------------------------------------
interface rcnh_target_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcnh_pkg::COORD_W-1:0]  target_x;
  logic signed [rcnh_pkg::COORD_W-1:0]  target_y;
  logic [rcnh_pkg::LEN_W-1:0]           target_radius;
  logic                                 target_active;
  logic                                 last_target;

  modport source (
    output valid, target_x, target_y, target_radius, target_active, last_target,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_radius, target_active, last_target,
    output ready
  );
endinterface

### src/rcnh_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_result_if
// Valid/ready channel carrying one scan result word.
// ----------------------------------------------------------------------------
interface rcnh_result_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [rcnh_pkg::INDEX_W-1:0]       hit_index;
  logic [rcnh_pkg::LEN_W-1:0]         hit_distance;

  modport source (
    output valid, hit, hit_index, hit_distance,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_index, hit_distance,
    output ready
  );
endinterface

### src/rcnh_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_cfg_regs
// APB register file holding the ray origin, direction and length limit.
// ----------------------------------------------------------------------------
module rcnh_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcnh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rcnh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rcnh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output rcnh_pkg::rcnh_cfg_t             cfg_o
);
  import rcnh_pkg::*;

  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic signed [DIR_W-1:0]   dir_x_q, dir_y_q;
  logic [LEN_W-1:0]          max_distance_q;
  logic [2:0]                reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      dir_x_q        <= '0;
      dir_y_q        <= '0;
      max_distance_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X:     origin_x_q     <= pwdata;
        REG_ORIGIN_Y:     origin_y_q     <= pwdata;
        REG_DIR_X:        dir_x_q        <= pwdata[DIR_W-1:0];
        REG_DIR_Y:        dir_y_q        <= pwdata[DIR_W-1:0];
        REG_MAX_DISTANCE: max_distance_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored bits
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:     prdata = origin_x_q;
      REG_ORIGIN_Y:     prdata = origin_y_q;
      REG_DIR_X:        prdata = {{(APB_DATA_W-DIR_W){1'b0}}, dir_x_q};
      REG_DIR_Y:        prdata = {{(APB_DATA_W-DIR_W){1'b0}}, dir_y_q};
      REG_MAX_DISTANCE: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, max_distance_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.origin_x     = origin_x_q;
  assign cfg_o.origin_y     = origin_y_q;
  assign cfg_o.dir_x        = dir_x_q;
  assign cfg_o.dir_y        = dir_y_q;
  assign cfg_o.max_distance = max_distance_q;

endmodule

### src/rcnh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_front
// Accepts target words, numbers them and classifies them for the back part.
// ----------------------------------------------------------------------------
module rcnh_front #(
  parameter int unsigned MAX_TARGETS = 1024,
  parameter int unsigned IDX_W       = 10,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcnh_pkg::rcnh_cfg_t   cfg_i,
  rcnh_target_if.sink           target_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output rcnh_pkg::rcnh_geom_t  q_geom_o,
  output logic [IDX_W-1:0]      q_pos_o
);
  import rcnh_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_window;
  logic             ray_ok;
  logic             accept;

  assign target_i.ready = !q_full_i;
  assign accept         = target_i.valid && !q_full_i;
  assign q_push_o       = accept;

  assign in_window = cnt_q < CNT_W'(MAX_TARGETS);
  assign ray_ok    = ((cfg_i.dir_x != '0) || (cfg_i.dir_y != '0))
                     && (cfg_i.max_distance != '0);

  // Offset from ray origin, exact in one extra bit
  assign q_geom_o.rel_x    = REL_W'(target_i.target_x) - REL_W'(cfg_i.origin_x);
  assign q_geom_o.rel_y    = REL_W'(target_i.target_y) - REL_W'(cfg_i.origin_y);
  assign q_geom_o.radius   = target_i.target_radius;
  assign q_geom_o.eligible = in_window && target_i.target_active
                             && (target_i.target_radius != '0) && ray_ok;
  assign q_geom_o.last     = target_i.last_target;
  assign q_pos_o           = cnt_q[IDX_W-1:0];

  // Advance position, saturate at the list limit, restart after the last word
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (target_i.last_target) begin
        cnt_d = '0;
      end else if (in_window) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/rcnh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_queue
// Short FIFO decoupling the classifying front from the geometry back part.
// ----------------------------------------------------------------------------
module rcnh_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import rcnh_pkg::*;

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### src/rcnh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnh_back
// Projects queued targets onto the ray, keeps the nearest hit, emits results.
// ----------------------------------------------------------------------------
`include "ray_circle_nearest_hit_assert.svh"

module rcnh_back #(
  parameter int unsigned IDX_W = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcnh_pkg::rcnh_cfg_t   cfg_i,
  input  logic                  q_valid_i,
  input  rcnh_pkg::rcnh_geom_t  q_geom_i,
  input  logic [IDX_W-1:0]      q_pos_i,
  output logic                  q_pop_o,
  rcnh_result_if.source         result_o
);
  import rcnh_pkg::*;

  localparam logic [NEAR_W-1:0] NEAR_INIT = '1;

  logic adv;

  // Stage 1: the four products
  logic                     s1_v_q;
  logic signed [PROD_W-1:0] s1_xx_q, s1_yy_q, s1_xy_q, s1_yx_q;
  logic [LEN_W-1:0]         s1_rad_q;
  logic                     s1_elig_q, s1_last_q;
  logic [IDX_W-1:0]         s1_pos_q;

  // Stage 2: projection and cross sums
  logic                    s2_v_q;
  logic signed [SUM_W-1:0] s2_proj_q, s2_cross_q;
  logic [LEN_W-1:0]        s2_rad_q;
  logic                    s2_elig_q, s2_last_q;
  logic [IDX_W-1:0]        s2_pos_q;

  // Stage 3: range and radius tests
  logic                    s3_v_q;
  logic                    s3_ok_q, s3_last_q;
  logic [LEN_W-1:0]        s3_dist_q;
  logic [IDX_W-1:0]        s3_pos_q;

  logic [SUM_W-FRAC_SHIFT-1:0] dist_full;
  logic [SUM_W-1:0]            cross_mag;
  logic [SUM_W-1:0]            rad_scaled;
  logic                        range_ok, radius_ok;

  // Running best and result register
  logic              found_q, found_d;
  logic [NEAR_W-1:0] near_q, near_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic              take;
  logic              out_v_q;
  logic              out_hit_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [LEN_W-1:0]  out_dist_q;

  // Hold the whole pipe while a finished scan waits on a full result register
  assign adv     = !(s3_v_q && s3_last_q && out_v_q && !result_o.ready);
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= q_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Multiply relative position by direction
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_xx_q   <= PROD_W'(q_geom_i.rel_x * cfg_i.dir_x);
      s1_yy_q   <= PROD_W'(q_geom_i.rel_y * cfg_i.dir_y);
      s1_xy_q   <= PROD_W'(q_geom_i.rel_x * cfg_i.dir_y);
      s1_yx_q   <= PROD_W'(q_geom_i.rel_y * cfg_i.dir_x);
      s1_rad_q  <= q_geom_i.radius;
      s1_elig_q <= q_geom_i.eligible && q_valid_i;
      s1_last_q <= q_geom_i.last;
      s1_pos_q  <= q_pos_i;
    end
  end

  // Sum into projection and cross value
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_proj_q  <= SUM_W'(s1_xx_q) + SUM_W'(s1_yy_q);
      s2_cross_q <= SUM_W'(s1_xy_q) - SUM_W'(s1_yx_q);
      s2_rad_q   <= s1_rad_q;
      s2_elig_q  <= s1_elig_q;
      s2_last_q  <= s1_last_q;
      s2_pos_q   <= s1_pos_q;
    end
  end

  // Floor to Q16.16 and test against the limit and the radius
  assign dist_full  = s2_proj_q[SUM_W-1:FRAC_SHIFT];
  assign range_ok   = !s2_proj_q[SUM_W-1]
                      && (dist_full <= (SUM_W-FRAC_SHIFT)'(cfg_i.max_distance));
  assign cross_mag  = s2_cross_q[SUM_W-1] ? (SUM_W'(0) - s2_cross_q) : s2_cross_q;
  assign rad_scaled = SUM_W'({s2_rad_q, {FRAC_SHIFT{1'b0}}});
  assign radius_ok  = cross_mag <= rad_scaled;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ok_q   <= s2_elig_q && range_ok && radius_ok;
      s3_dist_q <= dist_full[LEN_W-1:0];
      s3_last_q <= s2_last_q;
      s3_pos_q  <= s2_pos_q;
    end
  end

  // Keep the strictly nearer hit; ties keep the earlier target
  assign take    = s3_v_q && s3_ok_q && (NEAR_W'(s3_dist_q) < near_q);
  assign found_d = take ? 1'b1 : found_q;
  assign near_d  = take ? NEAR_W'(s3_dist_q) : near_q;
  assign best_d  = take ? s3_pos_q : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      near_q  <= NEAR_INIT;
      best_q  <= '0;
    end else if (adv && s3_v_q) begin
      if (s3_last_q) begin
        found_q <= 1'b0;
        near_q  <= NEAR_INIT;
        best_q  <= '0;
      end else begin
        found_q <= found_d;
        near_q  <= near_d;
        best_q  <= best_d;
      end
    end
  end

  // Load the result word at the end of a scan, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && s3_v_q && s3_last_q) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q && s3_last_q) begin
      out_hit_q  <= found_d;
      out_idx_q  <= found_d ? best_d : '0;
      out_dist_q <= found_d ? near_d[LEN_W-1:0] : '0;
    end
  end

  assign result_o.valid        = out_v_q;
  assign result_o.hit          = out_hit_q;
  assign result_o.hit_index    = INDEX_W'(out_idx_q);
  assign result_o.hit_distance = out_dist_q;

  `RCNH_IMPLY(a_nohit_zero, out_v_q && !out_hit_q, (out_idx_q == '0) && (out_dist_q == '0), "miss result carries nonzero fields")
  `RCNH_IMPLY(a_empty_best, !found_q, (near_q == NEAR_INIT) && (best_q == '0), "best state set without a hit")
  `RCNH_IMPLY_NEXT(a_stall_hold, !adv, s3_v_q && s3_last_q && $stable(s3_dist_q), "stalled scan end lost")

endmodule

### src/ray_circle_nearest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit
// Nearest ray/circle hit over a stream of targets, APB-configured ray.
// ----------------------------------------------------------------------------
// Targets are taken one word per cycle whenever the four-entry queue has room;
// the back part runs a three-stage product/sum/test pipeline and folds each
// target into the running best at one target per cycle while the pipe is not
// held, and it loads the result word once the last target of a scan leaves
// the test stage. The back pipe, and through the queue the input,
// waits only while a finished result sits unread and the next scan end
// arrives. Configure the ray over APB only while no scan is in flight.
module ray_circle_nearest_hit #(
  parameter int unsigned MAX_TARGETS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcnh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rcnh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rcnh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  rcnh_target_if.sink                     target_i,
  rcnh_result_if.source                   result_o
);
  import rcnh_pkg::*;

  localparam int unsigned IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int unsigned Q_W   = GEOM_W + IDX_W;

  rcnh_cfg_t        cfg;
  rcnh_geom_t       push_geom, pop_geom;
  logic [IDX_W-1:0] push_pos, pop_pos;
  logic             q_full, q_push, q_valid, q_pop;
  logic [Q_W-1:0]   q_rdata;

  rcnh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcnh_front #(
    .MAX_TARGETS (MAX_TARGETS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .target_i (target_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_geom_o (push_geom),
    .q_pos_o  (push_pos)
  );

  rcnh_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_geom, push_pos}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Split the queue word back into target and position
  assign pop_geom = q_rdata[Q_W-1:IDX_W];
  assign pop_pos  = q_rdata[IDX_W-1:0];

  rcnh_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_geom_i  (pop_geom),
    .q_pos_i   (pop_pos),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

### tb/ray_circle_nearest_hit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit_tb
// Self-checking bench for the ray/circle nearest hit search.
// ----------------------------------------------------------------------------
// Programs the ray over APB between phases and streams target words with
// random gaps. Every accepted target is folded into a local copy of the
// running best, which yields the scan result expected at each scan end.
// Result words are drained with random stalls, plus one long hold-off that
// backs the block up into its target input. A directed opening covers zero
// direction, zero limit, skipped targets, ties, tiny negative projections,
// radius and limit boundaries, extreme values and one scan that runs past
// the target limit; random phases follow.
// ----------------------------------------------------------------------------
module ray_circle_nearest_hit_tb;
  import rcnh_pkg::*;

  localparam int unsigned MAX_SCAN = 1024;
  localparam longint      ONE      = 64'sd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]          radius;
    logic                      active;
    logic                      last;
  } target_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0]   distance;
  } scan_result_t;

  // Unit direction components, Q2.14, first quadrant
  localparam int UNIT_A[8] = '{16384, 0, 11585, 13107, 9830, 15137, 6270, 16069};
  localparam int UNIT_B[8] = '{0, 16384, 11585, 9830, 13107, 6270, 15137, 3196};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rcnh_target_if tgt_if ();
  rcnh_result_if res_if ();

  ray_circle_nearest_hit #(
    .MAX_TARGETS(MAX_SCAN)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .target_i(tgt_if),
    .result_o(res_if)
  );

  always #4 clk_i = ~clk_i;

  // Ray registers as the block should hold them
  longint ray_ox, ray_oy, ray_dx, ray_dy, ray_max;
  // Running best of the open scan
  longint best_dist;
  bit     best_found;
  int     best_pos;
  int     scan_pos;

  target_t      target_backlog[$];
  scan_result_t nearest_hits_q[$];

  int  mismatch_count = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  tgt_taken = 1'b0;
  bit  hold_rx = 1'b0;
  bit  no_gaps = 1'b0;
  int  scan_left = 0;
  int  random_items = 0;
  target_t next_target;

  // Append one target word to the send backlog
  function automatic void add_target(input target_t tg);
    target_backlog = {target_backlog, tg};
  endfunction

  function automatic void clear_best();
    best_dist  = 64'h0000_0000_FFFF_FFFF;
    best_found = 1'b0;
    best_pos   = 0;
    scan_pos   = 0;
  endfunction

  // Fold one target into the running best; return 1 with the result at scan end
  function automatic bit fold_target(input target_t tg, output scan_result_t res);
    longint rx, ry, proj, along, perp, mag;
    bit     ray_ok;
    ray_ok = (ray_dx != 0 || ray_dy != 0) && ray_max != 0;
    if (scan_pos < MAX_SCAN && tg.active && tg.radius != 0 && ray_ok) begin
      rx   = longint'($signed(tg.x)) - ray_ox;
      ry   = longint'($signed(tg.y)) - ray_oy;
      proj = rx * ray_dx + ry * ray_dy;
      if (proj >= 0) begin
        along = proj >>> FRAC_SHIFT;
        if (along <= ray_max && along < best_dist) begin
          perp = rx * ray_dy - ry * ray_dx;
          mag  = (perp < 0) ? -perp : perp;
          if (mag <= (longint'(tg.radius) << FRAC_SHIFT)) begin
            best_dist  = along;
            best_found = 1'b1;
            best_pos   = scan_pos;
          end
        end
      end
    end
    if (scan_pos < MAX_SCAN) scan_pos++;
    res = '0;
    if (!tg.last) return 1'b0;
    if (best_found) begin
      res.hit      = 1'b1;
      res.index    = best_pos[INDEX_W-1:0];
      res.distance = best_dist[LEN_W-1:0];
    end
    clear_best();
    return 1'b1;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic target_t mk(longint x, longint y, longint r, bit act, bit lst);
    target_t tg;
    tg.x      = x[COORD_W-1:0];
    tg.y      = y[COORD_W-1:0];
    tg.radius = r[LEN_W-1:0];
    tg.active = act;
    tg.last   = lst;
    return tg;
  endfunction

  function automatic rcnh_cfg_t ray(longint ox, longint oy, longint dx, longint dy,
                                    longint mx);
    rcnh_cfg_t c;
    c.origin_x     = ox[COORD_W-1:0];
    c.origin_y     = oy[COORD_W-1:0];
    c.dir_x        = dx[DIR_W-1:0];
    c.dir_y        = dy[DIR_W-1:0];
    c.max_distance = mx[LEN_W-1:0];
    return c;
  endfunction

  function automatic rcnh_cfg_t rand_ray();
    rcnh_cfg_t   c;
    int unsigned k, r;
    r = $urandom_range(99);
    if (r < 70) begin
      c.origin_x = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      c.origin_y = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    end else begin
      c.origin_x = $urandom;
      c.origin_y = $urandom;
    end
    r = $urandom_range(99);
    k = $urandom_range(7);
    if (r < 85) begin
      c.dir_x = DIR_W'($urandom_range(1) ? -UNIT_A[k] : UNIT_A[k]);
      c.dir_y = DIR_W'($urandom_range(1) ? -UNIT_B[k] : UNIT_B[k]);
    end else if (r < 95) begin
      c.dir_x = DIR_W'($urandom);
      c.dir_y = DIR_W'($urandom);
    end else begin
      c.dir_x = '0;
      c.dir_y = '0;
    end
    r = $urandom_range(99);
    if (r < 60)      c.max_distance = LEN_W'($urandom_range(1, 2000) * 65536);
    else if (r < 80) c.max_distance = LEN_W'($urandom);
    else if (r < 90) c.max_distance = '1;
    else if (r < 95) c.max_distance = '0;
    else             c.max_distance = LEN_W'(1);
    return c;
  endfunction

  // Target placed near the ray: along-ray offset t, sideways offset off
  function automatic target_t near_target(rcnh_cfg_t c);
    target_t tg;
    longint  t, off, rad, dx, dy, px, py;
    dx  = longint'($signed(c.dir_x));
    dy  = longint'($signed(c.dir_y));
    rad = longint'($urandom_range(1, 1 << 22));
    if ($urandom_range(9) == 0) t = -longint'($urandom_range(1, 1 << 20));
    else t = (longint'($urandom_range(0, 1200)) * longint'(c.max_distance)) / 1000;
    off = longint'($urandom_range(0, 3 * rad)) - (3 * rad) / 2;
    px  = longint'($signed(c.origin_x)) + ((t * dx) >>> FRAC_SHIFT)
          - ((off * dy) >>> FRAC_SHIFT);
    py  = longint'($signed(c.origin_y)) + ((t * dy) >>> FRAC_SHIFT)
          + ((off * dx) >>> FRAC_SHIFT);
    tg  = mk(px, py, rad, $urandom_range(9) != 0, 1'b0);
    if ($urandom_range(24) == 0) tg.radius = '0;
    return tg;
  endfunction

  function automatic target_t noise_target();
    target_t tg;
    tg.x      = $urandom;
    tg.y      = $urandom;
    tg.radius = LEN_W'($urandom);
    tg.active = 1'($urandom_range(1));
    tg.last   = 1'b0;
    return tg;
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic apb_write(rcnh_reg_e idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ORIGIN_X:     ray_ox  = longint'($signed(value));
      REG_ORIGIN_Y:     ray_oy  = longint'($signed(value));
      REG_DIR_X:        ray_dx  = longint'($signed(value[DIR_W-1:0]));
      REG_DIR_Y:        ray_dy  = longint'($signed(value[DIR_W-1:0]));
      REG_MAX_DISTANCE: ray_max = longint'(value[LEN_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_ray(rcnh_cfg_t c);
    apb_write(REG_ORIGIN_X, c.origin_x);
    apb_write(REG_ORIGIN_Y, c.origin_y);
    apb_write(REG_DIR_X, 32'($signed(c.dir_x)));
    apb_write(REG_DIR_Y, 32'($signed(c.dir_y)));
    apb_write(REG_MAX_DISTANCE, {1'b0, c.max_distance});
  endtask

  // Wait until every target is taken and every result has come, then let
  // the pipeline settle in case trailing targets caused no result
  task automatic wait_drained();
    do @(posedge clk_i); while (target_backlog.size() != 0 || tgt_if.valid);
    while (nearest_hits_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // One random phase: new ray, then scans of random length
  task automatic run_phase(int n, bit hold);
    rcnh_cfg_t c;
    target_t   tg;
    int        long_odds;
    wait_drained();
    c = rand_ray();
    set_ray(c);
    no_gaps   = ($urandom_range(3) == 0);
    long_odds = hold ? 0 : 4;
    if (hold) hold_rx = 1'b1;
    for (int k = 0; k < n; k++) begin
      tg = ($urandom_range(4) == 0) ? noise_target() : near_target(c);
      if (scan_left == 0) begin
        if (hold) scan_left = $urandom_range(1, 3);
        else if ($urandom_range(long_odds) == 0) scan_left = $urandom_range(1, 40);
        else scan_left = $urandom_range(1, 8);
      end
      scan_left--;
      tg.last = (scan_left == 0) || (k == n - 1 && $urandom_range(4) != 0);
      if (tg.last) scan_left = 0;
      add_target(tg);
    end
    random_items += n;
  endtask

  // Send target words: advance after each acceptance, insert random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!tgt_if.valid || tgt_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        tgt_if.valid <= 1'b0;
      end else if (target_backlog.size() != 0) begin
        next_target = target_backlog.pop_front();
        tgt_if.target_x      <= next_target.x;
        tgt_if.target_y      <= next_target.y;
        tgt_if.target_radius <= next_target.radius;
        tgt_if.target_active <= next_target.active;
        tgt_if.last_target   <= next_target.last;
        tgt_if.valid         <= 1'b1;
        tx_gap = idle_len();
      end else begin
        tgt_if.valid <= 1'b0;
      end
    end
  end

  // Drain result words with random stalls; hold off entirely on request
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rx) begin
      res_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(4) == 0) rx_stall = idle_len();
    end
  end

  // Long receiver hold-off, counted here while targets keep coming
  initial begin
    wait (hold_rx);
    repeat (400) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // Predict on accepted targets, check accepted results
  always @(posedge clk_i) begin
    scan_result_t want, got;
    if (rst_ni) begin
      if (tgt_if.valid && tgt_if.ready) begin
        if (fold_target({tgt_if.target_x, tgt_if.target_y, tgt_if.target_radius,
                         tgt_if.target_active, tgt_if.last_target}, want))
          nearest_hits_q = {nearest_hits_q, want};
      end
      tgt_taken = tgt_if.valid && tgt_if.ready;
      if (res_if.valid && res_if.ready) begin
        got = {res_if.hit, res_if.hit_index, res_if.hit_distance};
        if (nearest_hits_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with no scan end pending: hit=%0b index=%0d dist=%0h",
                     $realtime, got.hit, got.index, got.distance);
        end else begin
          want = nearest_hits_q.pop_front();
          if (got.hit !== want.hit || got.index !== want.index ||
              got.distance !== want.distance) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch: expected hit=%0b index=%0d dist=%0h, got hit=%0b index=%0d dist=%0h",
                       $realtime, want.hit, want.index, want.distance,
                       got.hit, got.index, got.distance);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL ray_circle_nearest_hit");
    $finish;
  end

  initial begin
    rcnh_cfg_t c;
    bit        hold_done;
    hold_done = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tgt_if.valid         = 1'b0;
    tgt_if.target_x      = '0;
    tgt_if.target_y      = '0;
    tgt_if.target_radius = '0;
    tgt_if.target_active = 1'b0;
    tgt_if.last_target   = 1'b0;
    res_if.ready         = 1'b0;
    ray_ox  = 0;
    ray_oy  = 0;
    ray_dx  = 0;
    ray_dy  = 0;
    ray_max = 0;
    clear_best();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers still at reset: zero direction, no hit
    add_target(mk(10 * ONE, 0, ONE, 1'b1, 1'b1));
    wait_drained();

    // Zero limit with a valid direction: no hit
    set_ray(ray(0, 0, 16384, 0, 0));
    add_target(mk(10 * ONE, 0, ONE, 1'b1, 1'b1));
    wait_drained();

    // Skips, tie, negative projection, beyond limit, radius miss and exact edge
    set_ray(ray(0, 0, 16384, 0, 100 * ONE));
    add_target(mk(10 * ONE, 0, ONE, 1'b1, 1'b0));
    add_target(mk(5 * ONE, 0, ONE, 1'b0, 1'b0));
    add_target(mk(5 * ONE, 0, 0, 1'b1, 1'b0));
    add_target(mk(10 * ONE, 0, 2 * ONE, 1'b1, 1'b0));
    add_target(mk(-ONE, 0, 4 * ONE, 1'b1, 1'b0));
    add_target(mk(200 * ONE, 0, 64'h7FFF_FFFF, 1'b1, 1'b0));
    add_target(mk(8 * ONE, 2 * ONE, ONE, 1'b1, 1'b0));
    add_target(mk(9 * ONE, ONE, ONE, 1'b1, 1'b0));
    add_target(mk(50 * ONE, 0, ONE, 1'b1, 1'b1));
    wait_drained();

    // Short direction: a tiny positive projection floors to zero and hits,
    // a tiny negative one is still skipped
    set_ray(ray(0, 0, 3, 0, 100 * ONE));
    add_target(mk(5000, 0, ONE, 1'b1, 1'b0));
    add_target(mk(-1, 0, 5 * ONE, 1'b1, 1'b1));
    wait_drained();

    // Extreme origin, direction patterns and limit
    set_ray(ray(64'h8000_0000, 64'h7FFF_FFFF, 64'h8000, 64'h7FFF, 64'h7FFF_FFFF));
    add_target(mk(64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF, 1'b1, 1'b0));
    add_target(mk(64'h8000_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 1'b1, 1'b0));
    add_target(mk(0, 0, 64'h7FFF_FFFF, 1'b1, 1'b1));
    wait_drained();

    // Hit lying exactly at the limit
    set_ray(ray(0, 0, 0, -16384, 5 * ONE));
    add_target(mk(64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0, 1'b0));
    add_target(mk(0, -5 * ONE, 1, 1'b1, 1'b1));

    // One scan longer than the target limit; the tail must be ignored
    wait_drained();
    c = ray(0, 0, 16384, 0, 1000 * ONE);
    set_ray(c);
    for (int i = 0; i < MAX_SCAN + 6; i++) begin
      next_target = near_target(c);
      next_target.last = (i == MAX_SCAN + 5);
      add_target(next_target);
    end

    // Random phases, one of them under a long receiver hold-off
    while (random_items < 250) begin
      if (!hold_done && random_items >= 60) begin
        run_phase(120, 1'b1);
        hold_done = 1'b1;
      end else begin
        run_phase($urandom_range(40, 100), 1'b0);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS ray_circle_nearest_hit");
    end else begin
      $display("FAIL ray_circle_nearest_hit");
    end
    $finish;
  end

endmodule
